>>> rtl/mxl_pkg.sv
// Shared types, constants and helpers for the maxout linear layer.
`default_nettype none
package mxl_pkg;

	localparam int POSITIONS_DEF = 4;
	localparam int IN_SIZE_DEF   = 16;
	localparam int OUT_SIZE_DEF  = 16;

	localparam int OP_W    = 2;
	localparam int INDEX_W = 10;
	localparam int VALUE_W = 16;
	localparam int PROD_W  = 32;
	localparam int ACT_W   = 32;
	localparam int UNIT_W  = 4;
	localparam int WIN_W   = 2;
	localparam int FRAC_W  = 12;

	localparam logic [OP_W-1:0] OP_WEIGHT  = 2'd0;
	localparam logic [OP_W-1:0] OP_BIAS    = 2'd1;
	localparam logic [OP_W-1:0] OP_FEATURE = 2'd2;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_WEIGHT,
		CMD_BIAS,
		CMD_FEATURE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                   kind;
		logic                        start;
		logic [INDEX_W-1:0]          addr;
		logic signed [VALUE_W-1:0]   value;
	} cmd_t;

	typedef struct packed {
		logic first_i;
		logic last_i;
		logic first_p;
		logic last_p;
		logic last_o;
	} tag_t;

	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} back_state_t;

	function automatic int cw(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage
`default_nettype wire

>>> rtl/maxout_linear_layer.sv
// Top level of the maxout linear layer: command front end, MAC back end, checks.
//
//  channel  direction  handshake                    words
//  feed     in         feed_valid / feed_ready      op, index, value, last
//  result   out        result_valid / result_ready  unit, activation, winner, end_of_sample
//
// The back end takes store writes only while idle; a two-entry queue sits in front.
// A feature word with last starts a pass of OUT_SIZE*POSITIONS*IN_SIZE products (1024 by default),
// one product per cycle through the single shared multiplier while no held result stalls it;
// the pass gives one result per output unit.
// Reset clears control only; weight, bias and feature stores keep whatever they hold.
// A held result stalls the whole MAC pipeline; the front keeps taking words until its queue fills.
`default_nettype none
module maxout_linear_layer #(
	parameter int POSITIONS = mxl_pkg::POSITIONS_DEF,
	parameter int IN_SIZE   = mxl_pkg::IN_SIZE_DEF,
	parameter int OUT_SIZE  = mxl_pkg::OUT_SIZE_DEF
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    feed_valid,
	output logic                                   feed_ready,
	input  wire  [mxl_pkg::OP_W-1:0]               op,
	input  wire  [mxl_pkg::INDEX_W-1:0]            index,
	input  wire  signed [mxl_pkg::VALUE_W-1:0]     value,
	input  wire                                    last,
	output logic                                   result_valid,
	input  wire                                    result_ready,
	output logic [mxl_pkg::UNIT_W-1:0]             unit,
	output logic signed [mxl_pkg::ACT_W-1:0]       activation,
	output logic [mxl_pkg::WIN_W-1:0]              winner,
	output logic                                   end_of_sample
);

	localparam int LAST_UNIT = (OUT_SIZE - 1) % (1 << mxl_pkg::UNIT_W);
	localparam int WIN_SPAN  = 1 << mxl_pkg::WIN_W;

	logic          cmd_valid;
	logic          cmd_ready;
	mxl_pkg::cmd_t cmd;

	mxl_front #(
		.POSITIONS (POSITIONS),
		.IN_SIZE   (IN_SIZE),
		.OUT_SIZE  (OUT_SIZE)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.feed_valid (feed_valid),
		.feed_ready (feed_ready),
		.op         (op),
		.index      (index),
		.value      (value),
		.last       (last),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd)
	);

	mxl_back #(
		.POSITIONS (POSITIONS),
		.IN_SIZE   (IN_SIZE),
		.OUT_SIZE  (OUT_SIZE)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready),
		.cmd           (cmd),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.unit          (unit),
		.activation    (activation),
		.winner        (winner),
		.end_of_sample (end_of_sample)
	);

	a_eos_on_last_unit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && end_of_sample |-> 32'(unit) == LAST_UNIT)
		else $error("end_of_sample on a unit other than the last");

	a_winner_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (POSITIONS >= WIN_SPAN) || (32'(winner) < POSITIONS))
		else $error("winner outside the position range");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd.start |=> !cmd_ready)
		else $error("back end took a command right after starting a pass");

endmodule
`default_nettype wire

>>> rtl/mxl_front.sv
// Front end: decodes input words into store commands and queues them.
`default_nettype none
module mxl_front #(
	parameter int POSITIONS = mxl_pkg::POSITIONS_DEF,
	parameter int IN_SIZE   = mxl_pkg::IN_SIZE_DEF,
	parameter int OUT_SIZE  = mxl_pkg::OUT_SIZE_DEF
) (
	input  wire                                      clk,
	input  wire                                      arst_n,
	input  wire                                      feed_valid,
	output logic                                     feed_ready,
	input  wire  [mxl_pkg::OP_W-1:0]                 op,
	input  wire  [mxl_pkg::INDEX_W-1:0]              index,
	input  wire  signed [mxl_pkg::VALUE_W-1:0]       value,
	input  wire                                      last,
	output logic                                     cmd_valid,
	input  wire                                      cmd_ready,
	output mxl_pkg::cmd_t                            cmd
);

	localparam int W_DEPTH = POSITIONS * IN_SIZE * OUT_SIZE;
	localparam int F_DEPTH = POSITIONS * IN_SIZE;
	localparam logic [1:0] QUEUE_FULL = 2'd2;

	mxl_pkg::cmd_t dec;
	logic          keep;
	logic          push;
	logic          pop;

	mxl_pkg::cmd_t slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	always_comb begin
		dec.kind  = mxl_pkg::CMD_NONE;
		dec.start = 1'b0;
		dec.addr  = index;
		dec.value = value;
		case (op)
			mxl_pkg::OP_WEIGHT: begin
				if (32'(index) < W_DEPTH) dec.kind = mxl_pkg::CMD_WEIGHT;
			end
			mxl_pkg::OP_BIAS: begin
				if (32'(index) < OUT_SIZE) dec.kind = mxl_pkg::CMD_BIAS;
			end
			mxl_pkg::OP_FEATURE: begin
				if (32'(index) < F_DEPTH) dec.kind = mxl_pkg::CMD_FEATURE;
				dec.start = last;
			end
			default: begin
				dec.kind = mxl_pkg::CMD_NONE;
			end
		endcase
		keep = (dec.kind != mxl_pkg::CMD_NONE) || dec.start;
	end

	// dropped words are still taken
	assign feed_ready = (count_q != QUEUE_FULL);
	assign push       = feed_valid && feed_ready && keep;
	assign cmd_valid  = (count_q != 2'd0);
	assign pop        = cmd_valid && cmd_ready;
	assign cmd        = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule
`default_nettype wire

>>> rtl/mxl_back.sv
// Back end: owns the stores and runs the shared multiply-accumulate sequence.
`default_nettype none
module mxl_back #(
	parameter int POSITIONS = mxl_pkg::POSITIONS_DEF,
	parameter int IN_SIZE   = mxl_pkg::IN_SIZE_DEF,
	parameter int OUT_SIZE  = mxl_pkg::OUT_SIZE_DEF
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    cmd_valid,
	output logic                                   cmd_ready,
	input  mxl_pkg::cmd_t                          cmd,
	output logic                                   result_valid,
	input  wire                                    result_ready,
	output logic [mxl_pkg::UNIT_W-1:0]             unit,
	output logic signed [mxl_pkg::ACT_W-1:0]       activation,
	output logic [mxl_pkg::WIN_W-1:0]              winner,
	output logic                                   end_of_sample
);

	localparam int W_DEPTH = POSITIONS * IN_SIZE * OUT_SIZE;
	localparam int F_DEPTH = POSITIONS * IN_SIZE;
	localparam int WAW     = mxl_pkg::cw(W_DEPTH);
	localparam int FAW     = mxl_pkg::cw(F_DEPTH);
	localparam int PW      = mxl_pkg::cw(POSITIONS);
	localparam int IW      = mxl_pkg::cw(IN_SIZE);
	localparam int OW      = mxl_pkg::cw(OUT_SIZE);
	localparam int AW      = mxl_pkg::PROD_W + 1 + $clog2(IN_SIZE);
	localparam int SW      = AW + 1;
	localparam int VW      = mxl_pkg::VALUE_W;
	localparam int ROUND_HALF = 1 << (mxl_pkg::FRAC_W - 1);
	localparam logic signed [SW-1:0] ACT_MAX = SW'(64'sd2147483647);
	localparam logic signed [SW-1:0] ACT_MIN = SW'(-64'sd2147483648);

	logic signed [VW-1:0] wmem [W_DEPTH];
	logic signed [VW-1:0] fmem [F_DEPTH];
	logic signed [VW-1:0] bmem [OUT_SIZE];

	mxl_pkg::back_state_t state_q, state_d;
	logic [IW-1:0] i_q;
	logic [PW-1:0] p_q;
	logic [OW-1:0] o_q;
	logic          li, lp, lo;
	logic          pop, run_issue, adv;
	logic          we_w, we_f, we_b;
	logic [WAW-1:0] waddr;
	logic [FAW-1:0] faddr;

	logic                 vld_s1, vld_s2, vld_s3;
	mxl_pkg::tag_t        tag_s1, tag_s2;
	logic [PW-1:0]        pos_s1, pos_s2;
	logic [OW-1:0]        unit_s1, unit_s2, unit_s3;
	logic signed [VW-1:0] w_s1, f_s1, b_s1, b_s2, bias_s3;
	logic signed [mxl_pkg::PROD_W-1:0] prod_s2;
	logic signed [AW-1:0] acc_q, best_q, best_s3;
	logic [PW-1:0]        win_q, win_s3;
	logic                 eos_s3;

	logic signed [AW-1:0] dot, best_n;
	logic [PW-1:0]        win_n;
	logic                 take, fire;

	logic signed [SW-1:0] sum, quo;
	logic signed [mxl_pkg::ACT_W-1:0] act_n;

	logic                              result_valid_q;
	logic [mxl_pkg::UNIT_W-1:0]        unit_q;
	logic signed [mxl_pkg::ACT_W-1:0]  act_q;
	logic [mxl_pkg::WIN_W-1:0]         winner_q;
	logic                              eos_q;

	assign li  = (i_q == IW'(IN_SIZE - 1));
	assign lp  = (p_q == PW'(POSITIONS - 1));
	assign lo  = (o_q == OW'(OUT_SIZE - 1));
	assign adv = !result_valid_q || result_ready;

	assign waddr = WAW'((32'(p_q) * OUT_SIZE + 32'(o_q)) * IN_SIZE + 32'(i_q));
	assign faddr = FAW'(32'(p_q) * IN_SIZE + 32'(i_q));

	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		run_issue = 1'b0;
		case (state_q)
			mxl_pkg::BK_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid && cmd.start) state_d = mxl_pkg::BK_RUN;
			end
			mxl_pkg::BK_RUN: begin
				run_issue = adv;
				if (adv && li && lp && lo) state_d = mxl_pkg::BK_IDLE;
			end
			default: begin
				state_d = mxl_pkg::BK_IDLE;
			end
		endcase
	end

	assign pop  = cmd_valid && cmd_ready;
	assign we_w = pop && (cmd.kind == mxl_pkg::CMD_WEIGHT);
	assign we_b = pop && (cmd.kind == mxl_pkg::CMD_BIAS);
	assign we_f = pop && (cmd.kind == mxl_pkg::CMD_FEATURE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mxl_pkg::BK_IDLE;
			i_q     <= '0;
			p_q     <= '0;
			o_q     <= '0;
		end else begin
			state_q <= state_d;
			if (pop && cmd.start) begin
				i_q <= '0;
				p_q <= '0;
				o_q <= '0;
			end else if (run_issue) begin
				if (!li) begin
					i_q <= i_q + IW'(1);
				end else begin
					i_q <= '0;
					if (!lp) begin
						p_q <= p_q + PW'(1);
					end else begin
						p_q <= '0;
						o_q <= lo ? '0 : o_q + OW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we_w) wmem[WAW'(cmd.addr)] <= cmd.value;
		if (run_issue) w_s1 <= wmem[waddr];
	end

	always_ff @(posedge clk) begin
		if (we_f) fmem[FAW'(cmd.addr)] <= cmd.value;
		if (run_issue) f_s1 <= fmem[faddr];
	end

	always_ff @(posedge clk) begin
		if (we_b) bmem[OW'(cmd.addr)] <= cmd.value;
		if (run_issue) b_s1 <= bmem[o_q];
	end

	// dot product, running max over positions
	always_comb begin
		dot    = tag_s2.first_i ? AW'(prod_s2) : acc_q + AW'(prod_s2);
		take   = tag_s2.first_p || (dot > best_q);
		best_n = take ? dot : best_q;
		win_n  = take ? pos_s2 : win_q;
		fire   = vld_s2 && tag_s2.last_i && tag_s2.last_p;
	end

	// bias, round half up, saturate
	always_comb begin
		sum = SW'(best_s3) + (SW'(bias_s3) <<< mxl_pkg::FRAC_W) + SW'(ROUND_HALF);
		quo = sum >>> mxl_pkg::FRAC_W;
		if (quo > ACT_MAX) begin
			act_n = ACT_MAX[mxl_pkg::ACT_W-1:0];
		end else if (quo < ACT_MIN) begin
			act_n = ACT_MIN[mxl_pkg::ACT_W-1:0];
		end else begin
			act_n = quo[mxl_pkg::ACT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (run_issue) begin
			tag_s1.first_i <= (i_q == '0);
			tag_s1.last_i  <= li;
			tag_s1.first_p <= (p_q == '0);
			tag_s1.last_p  <= lp;
			tag_s1.last_o  <= lo;
			pos_s1         <= p_q;
			unit_s1        <= o_q;
		end
		if (adv) begin
			tag_s2  <= tag_s1;
			pos_s2  <= pos_s1;
			unit_s2 <= unit_s1;
			b_s2    <= b_s1;
			prod_s2 <= w_s1 * f_s1;
			if (vld_s2) acc_q <= dot;
			if (vld_s2 && tag_s2.last_i) begin
				best_q <= best_n;
				win_q  <= win_n;
			end
			if (fire) begin
				best_s3 <= best_n;
				win_s3  <= win_n;
				unit_s3 <= unit_s2;
				bias_s3 <= b_s2;
				eos_s3  <= tag_s2.last_o;
			end
			if (vld_s3) begin
				act_q    <= act_n;
				unit_q   <= mxl_pkg::UNIT_W'(unit_s3);
				winner_q <= mxl_pkg::WIN_W'(win_s3);
				eos_q    <= eos_s3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1         <= 1'b0;
			vld_s2         <= 1'b0;
			vld_s3         <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1         <= run_issue;
			vld_s2         <= vld_s1;
			vld_s3         <= fire;
			result_valid_q <= vld_s3;
		end
	end

	assign result_valid  = result_valid_q;
	assign unit          = unit_q;
	assign activation    = act_q;
	assign winner        = winner_q;
	assign end_of_sample = eos_q;

endmodule
`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for the maxout linear layer: preload, directed table, random samples.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int POS_N   = mxl_pkg::POSITIONS_DEF;
	localparam int IN_N    = mxl_pkg::IN_SIZE_DEF;
	localparam int OUT_N   = mxl_pkg::OUT_SIZE_DEF;
	localparam int OP_W    = mxl_pkg::OP_W;
	localparam int INDEX_W = mxl_pkg::INDEX_W;
	localparam int VALUE_W = mxl_pkg::VALUE_W;
	localparam int ACT_W   = mxl_pkg::ACT_W;
	localparam int UNIT_W  = mxl_pkg::UNIT_W;
	localparam int WIN_W   = mxl_pkg::WIN_W;
	localparam int FRAC_W  = mxl_pkg::FRAC_W;
	localparam int W_N     = POS_N * IN_N * OUT_N;
	localparam int FEAT_N  = POS_N * IN_N;
	localparam int DIR_N   = 21;
	localparam int RAND_N  = 330;
	localparam int HOLD_AT = 250;
	localparam int HOLD_CY = 3000;
	localparam int DRAIN_AT = 200;
	localparam int PASS_CY = 1500;
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0] op;
		int              idx;
		int              val;
		logic            lst;
		logic            typed;
		int              act;
		int              win;
	} dir_row_t;

	typedef struct {
		logic [UNIT_W-1:0]        unit;
		logic signed [ACT_W-1:0]  activation;
		logic [WIN_W-1:0]         winner;
		logic                     eos;
	} unit_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic feed_valid = 1'b0;
	logic feed_ready;
	logic [OP_W-1:0] op = '0;
	logic [INDEX_W-1:0] index = '0;
	logic signed [VALUE_W-1:0] value = '0;
	logic last = 1'b0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic [UNIT_W-1:0] unit;
	logic signed [ACT_W-1:0] activation;
	logic [WIN_W-1:0] winner;
	logic end_of_sample;

	logic signed [VALUE_W-1:0] wt_mem [W_N];
	logic signed [VALUE_W-1:0] bias_mem [OUT_N];
	logic signed [VALUE_W-1:0] feat_mem [FEAT_N];

	unit_result_t act_q[$];
	dir_row_t dir_tab [DIR_N];
	int mismatches = 0;
	int got_cnt = 0;
	bit calm_tx = 1'b0;

	maxout_linear_layer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.feed_valid(feed_valid),
		.feed_ready(feed_ready),
		.op(op),
		.index(index),
		.value(value),
		.last(last),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.unit(unit),
		.activation(activation),
		.winner(winner),
		.end_of_sample(end_of_sample)
	);

	always #5 clk = ~clk;

	initial begin
		#50_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic longint unit_dot(input int pos, input int u);
		longint acc = 0;
		for (int i = 0; i < IN_N; i++) begin
			acc += longint'(wt_mem[(pos * OUT_N + u) * IN_N + i]) *
				longint'(feat_mem[pos * IN_N + i]);
		end
		return acc;
	endfunction

	// store writes and, on a sample's last word, one expected result per unit
	function automatic void layer_word(input logic [OP_W-1:0] o, input int i, input int v,
		input logic l);
		longint best;
		longint d;
		longint q;
		longint hi;
		int win;
		unit_result_t r;
		hi = (longint'(1) <<< (ACT_W - 1)) - 1;
		case (o)
			mxl_pkg::OP_WEIGHT: begin
				if (i < W_N) wt_mem[i] = v[VALUE_W-1:0];
			end
			mxl_pkg::OP_BIAS: begin
				if (i < OUT_N) bias_mem[i] = v[VALUE_W-1:0];
			end
			mxl_pkg::OP_FEATURE: begin
				if (i < FEAT_N) feat_mem[i] = v[VALUE_W-1:0];
				if (l) begin
					for (int u = 0; u < OUT_N; u++) begin
						best = unit_dot(0, u);
						win = 0;
						for (int p = 1; p < POS_N; p++) begin
							d = unit_dot(p, u);
							if (d > best) begin
								best = d;
								win = p;
							end
						end
						q = (best + (longint'(bias_mem[u]) <<< FRAC_W) +
							(longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
						if (q > hi) q = hi;
						if (q < -hi - 1) q = -hi - 1;
						r.unit = u[UNIT_W-1:0];
						r.activation = q[ACT_W-1:0];
						r.winner = win[WIN_W-1:0];
						r.eos = (u == OUT_N - 1);
						act_q.push_back(r);
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic int pick_value();
		case ($urandom_range(0, 9))
			0: return 32767;
			1: return -32768;
			2: return 0;
			3: return $urandom_range(0, 8) - 4;
			default: return $urandom_range(0, 65535) - 32768;
		endcase
	endfunction

	task automatic send_word(input logic [OP_W-1:0] o, input int i, input int v, input logic l);
		int gap;
		gap = calm_tx ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			feed_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		feed_valid <= 1'b1;
		op <= o;
		index <= i[INDEX_W-1:0];
		value <= v[VALUE_W-1:0];
		last <= l;
		do @(posedge clk); while (!feed_ready);
		layer_word(o, i, v, l);
	endtask

	// result side: random stalls, one long hold-off, a stretch with no stalls
	initial begin
		int stall;
		unit_result_t e;
		wait (arst_n);
		forever begin
			stall = (got_cnt >= 400 && got_cnt < 480) ? 0 : $urandom_range(0, 10);
			if (got_cnt == HOLD_AT) stall = HOLD_CY;
			if (stall != 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!(result_valid && result_ready));
			got_cnt++;
			if (act_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: unit %0d act %0d winner %0d eos %0d",
						unit, activation, winner, end_of_sample);
			end else begin
				e = act_q.pop_front();
				if (e.unit !== unit || e.activation !== activation || e.winner !== winner ||
					e.eos !== end_of_sample) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp unit %0d act %0d winner %0d eos %0d, ",
							"got unit %0d act %0d winner %0d eos %0d"},
							e.unit, e.activation, e.winner, e.eos,
							unit, activation, winner, end_of_sample);
				end
			end
		end
	end

	initial begin
		unit_result_t tail;
		int roll;
		int n;
		int idx;
		int sent;
		bit drained;
		// bias 15 and the feature/weight words touched below set unit 15 to readable values;
		// the preload leaves every feature at zero
		dir_tab[0]  = '{mxl_pkg::OP_BIAS,    15,   32767,  1'b1, 1'b0, 0,      0};
		dir_tab[1]  = '{mxl_pkg::OP_FEATURE, 0,    0,      1'b1, 1'b1, 32767,  0};
		dir_tab[2]  = '{mxl_pkg::OP_BIAS,    15,   -32768, 1'b0, 1'b0, 0,      0};
		dir_tab[3]  = '{mxl_pkg::OP_FEATURE, 63,   0,      1'b1, 1'b1, -32768, 0};
		dir_tab[4]  = '{OP_SPARE,            1023, -1,     1'b1, 1'b0, 0,      0};
		dir_tab[5]  = '{mxl_pkg::OP_WEIGHT,  1023, -32768, 1'b1, 1'b0, 0,      0};
		dir_tab[6]  = '{mxl_pkg::OP_FEATURE, 63,   -32768, 1'b1, 1'b1, 229376, 3};
		dir_tab[7]  = '{mxl_pkg::OP_BIAS,    16,   1234,   1'b0, 1'b0, 0,      0};
		dir_tab[8]  = '{mxl_pkg::OP_BIAS,    1023, 4321,   1'b1, 1'b0, 0,      0};
		dir_tab[9]  = '{mxl_pkg::OP_FEATURE, 64,   555,    1'b1, 1'b1, 229376, 3};
		dir_tab[10] = '{mxl_pkg::OP_FEATURE, 1023, 32767,  1'b1, 1'b1, 229376, 3};
		dir_tab[11] = '{mxl_pkg::OP_FEATURE, 63,   0,      1'b0, 1'b0, 0,      0};
		dir_tab[12] = '{mxl_pkg::OP_BIAS,    15,   0,      1'b0, 1'b0, 0,      0};
		dir_tab[13] = '{mxl_pkg::OP_WEIGHT,  240,  2048,   1'b0, 1'b0, 0,      0};
		dir_tab[14] = '{mxl_pkg::OP_FEATURE, 0,    1,      1'b1, 1'b1, 1,      0};
		dir_tab[15] = '{mxl_pkg::OP_WEIGHT,  240,  -2048,  1'b0, 1'b0, 0,      0};
		dir_tab[16] = '{mxl_pkg::OP_FEATURE, 0,    1,      1'b1, 1'b1, 0,      1};
		dir_tab[17] = '{mxl_pkg::OP_WEIGHT,  240,  32767,  1'b0, 1'b0, 0,      0};
		dir_tab[18] = '{mxl_pkg::OP_FEATURE, 0,    32767,  1'b1, 1'b1, 262128, 0};
		dir_tab[19] = '{mxl_pkg::OP_FEATURE, 0,    -32768, 1'b1, 1'b1, 0,      1};
		dir_tab[20] = '{mxl_pkg::OP_FEATURE, 0,    0,      1'b0, 1'b0, 0,      0};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int a = 0; a < W_N; a++)
			send_word(mxl_pkg::OP_WEIGHT, a, pick_value(), 1'($urandom_range(0, 1)));
		for (int a = 0; a < OUT_N; a++)
			send_word(mxl_pkg::OP_BIAS, a, pick_value(), 1'($urandom_range(0, 1)));
		for (int a = 0; a < FEAT_N; a++) send_word(mxl_pkg::OP_FEATURE, a, 0, 1'b0);

		for (int r = 0; r < DIR_N; r++) begin
			send_word(dir_tab[r].op, dir_tab[r].idx, dir_tab[r].val, dir_tab[r].lst);
			if (dir_tab[r].typed) begin
				tail = act_q.pop_back();
				tail.activation = dir_tab[r].act;
				tail.winner = dir_tab[r].win[WIN_W-1:0];
				act_q.push_back(tail);
			end
		end

		sent = 0;
		drained = 1'b0;
		while (sent < RAND_N) begin
			calm_tx = (sent >= 120 && sent < 170);
			if (!drained && sent >= DRAIN_AT) begin
				drained = 1'b1;
				feed_valid <= 1'b0;
				do @(posedge clk); while (act_q.size() != 0);
			end
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				n = $urandom_range(1, 8);
				for (int k = 0; k < n; k++) begin
					idx = $urandom_range(0, FEAT_N - 1);
					if (k == n - 1 && $urandom_range(0, 9) == 0)
						idx = $urandom_range(FEAT_N, (1 << INDEX_W) - 1);
					send_word(mxl_pkg::OP_FEATURE, idx, pick_value(), k == n - 1);
					sent++;
				end
			end else if (roll < 85) begin
				send_word(mxl_pkg::OP_WEIGHT, $urandom_range(0, W_N - 1), pick_value(),
					1'($urandom_range(0, 1)));
				sent++;
			end else if (roll < 93) begin
				send_word(mxl_pkg::OP_BIAS, $urandom_range(0, 2 * OUT_N - 1), pick_value(),
					1'($urandom_range(0, 1)));
				sent++;
			end else begin
				send_word(OP_SPARE, $urandom_range(0, (1 << INDEX_W) - 1), pick_value(),
					1'($urandom_range(0, 1)));
				sent++;
			end
		end
		feed_valid <= 1'b0;

		while (act_q.size() != 0) @(posedge clk);
		repeat (PASS_CY) @(posedge clk);
		if (mismatches == 0 && act_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
